// ===== hw/rtl/tleb_pkg.sv =====
// ----------------------------------------------------------------------------
// tleb_pkg
// Types, codes and constants shared by the line edit buffer modules.
// ----------------------------------------------------------------------------
package tleb_pkg;

  localparam int CAP_W  = 6;
  localparam int CHAR_W = 7;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;
  localparam int IDX_W  = 2;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 6'd25;
  localparam logic [CHAR_W-1:0] LOW_RESET  = 7'd97;
  localparam logic [CHAR_W-1:0] HIGH_RESET = 7'd122;

  localparam logic [BYTE_W-1:0] KEY_ESC   = 8'd27;
  localparam logic [BYTE_W-1:0] KEY_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] KEY_BS    = 8'd127;
  localparam logic [BYTE_W-1:0] KEY_CSI   = 8'd91;
  localparam logic [BYTE_W-1:0] KEY_LEFT  = 8'd68;
  localparam logic [BYTE_W-1:0] KEY_RIGHT = 8'd67;
  localparam logic [BYTE_W-1:0] KEY_BOL   = 8'd72;
  localparam logic [BYTE_W-1:0] KEY_END   = 8'd70;
  localparam logic [BYTE_W-1:0] KEY_DEL   = 8'd51;

  typedef enum logic [1:0] {
    REG_CAPACITY  = 2'd0,
    REG_INS_LOW   = 2'd1,
    REG_INS_HIGH  = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_SEEN  = 2'd1,
    ESC_FIRST = 2'd2,
    ESC_DELX  = 2'd3
  } esc_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_CANCEL = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    EFF_NONE     = 3'd0,
    EFF_INSERTED = 3'd1,
    EFF_FULL     = 3'd2,
    EFF_MOVED    = 3'd3,
    EFF_REMOVED  = 3'd4
  } effect_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_SHIFT_R = 2'd1,
    OP_SHIFT_L = 2'd2,
    OP_EMIT    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_SHIFT_R = 3'd1,
    ST_SHIFT_L = 3'd2,
    ST_EMIT    = 3'd3,
    ST_DRAIN   = 3'd4
  } state_e;

  typedef struct packed {
    logic accept;
    logic shift_r;
    logic shift_l;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic at_lim;
    logic pend;
  } stat_t;

endpackage

// ===== hw/rtl/tleb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tleb_ctrl
// Sequencer for the line edit buffer: runs store shifts and line emission.
// ----------------------------------------------------------------------------
module tleb_ctrl
  import tleb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (stat_i.op)
            OP_SHIFT_R: state_d = ST_SHIFT_R;
            OP_SHIFT_L: state_d = ST_SHIFT_L;
            OP_EMIT:    state_d = ST_EMIT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SHIFT_R, ST_SHIFT_L, ST_EMIT: begin
        if (stat_i.at_lim) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat_i.pend) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      ST_SHIFT_R: cmd_o.shift_r = 1'b1;
      ST_SHIFT_L: cmd_o.shift_l = 1'b1;
      ST_EMIT:    cmd_o.emit    = 1'b1;
      ST_DRAIN:   cmd_o         = '0;
      default:    cmd_o         = '0;
    endcase
  end

endmodule

// ===== hw/rtl/tleb_dp.sv =====
// ----------------------------------------------------------------------------
// tleb_dp
// Datapath: key decode, line store, cursor and length, result register.
// ----------------------------------------------------------------------------
module tleb_dp
  import tleb_pkg::*;
#(
  parameter int MAX_LEN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [BYTE_W-1:0] key_byte_i,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CHAR_W-1:0] cfg_data_i,
  output logic              result_valid_o,
  output logic [1:0]        result_kind_o,
  output logic [CHAR_W-1:0] char_out_o,
  output logic [POS_W-1:0]  cursor_pos_o,
  output logic [POS_W-1:0]  line_len_o,
  output logic [2:0]        key_effect_o,
  output logic              last_item_o
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int XW = 8;

  logic [CHAR_W-1:0] mem_q [MAX_LEN];
  logic [CHAR_W-1:0] rd_q;
  logic              ren;
  logic [AW-1:0]     raddr;

  logic [CW-1:0]     fill_q, fill_d, cur_q, cur_d, ptr_q, ptr_d, lim_q, lim_d;
  esc_e              esc_q, esc_d;
  logic [BYTE_W-1:0] first_q, first_d;
  logic [CAP_W-1:0]  cap_q;
  logic [CHAR_W-1:0] low_q, high_q;
  logic [CHAR_W-1:0] key_q, key_d;
  logic              wr_pend_q, wr_pend_d, wr_key_q, wr_key_d;
  logic [AW-1:0]     wr_addr_q, wr_addr_d;
  logic              em_pend_q, em_pend_d, em_last_q, em_last_d;

  logic              out_valid_q, out_valid_d;
  kind_e             kind_q, kind_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic [POS_W-1:0]  curo_q, curo_d, leno_q, leno_d;
  effect_e           eff_q, eff_d;
  logic              last_q, last_d;

  logic [CW-1:0]     nf, nc, np, nl;
  esc_e              ne;
  logic [BYTE_W-1:0] nfirst;
  logic [CHAR_W-1:0] nkey;
  logic              res_en;
  kind_e             res_kind;
  effect_e           res_eff;
  op_e               op;
  logic [XW-1:0]     cap_x, fill_x;

  assign cap_x  = (XW'(cap_q) > XW'(MAX_LEN)) ? XW'(MAX_LEN) : XW'(cap_q);
  assign fill_x = XW'(fill_q);

  // decode one byte against the current line state
  always_comb begin
    nf       = fill_q;
    nc       = cur_q;
    np       = ptr_q;
    nl       = lim_q;
    ne       = esc_q;
    nfirst   = first_q;
    nkey     = key_q;
    res_en   = 1'b0;
    res_kind = KIND_STATUS;
    res_eff  = EFF_NONE;
    op       = OP_NONE;
    unique case (esc_q)
      ESC_SEEN: begin
        nfirst = key_byte_i;
        ne     = ESC_FIRST;
      end
      ESC_FIRST: begin
        ne     = ESC_IDLE;
        res_en = 1'b1;
        if (first_q == KEY_CSI) begin
          unique case (key_byte_i)
            KEY_LEFT:  nc = (cur_q != '0) ? cur_q - CW'(1) : '0;
            KEY_RIGHT: nc = (cur_q < fill_q) ? cur_q + CW'(1) : cur_q;
            KEY_BOL:   nc = '0;
            KEY_END:   nc = fill_q;
            KEY_DEL: begin
              res_en = 1'b0;
              ne     = ESC_DELX;
            end
            default: begin
              res_kind = KIND_CANCEL;
              nf       = '0;
              nc       = '0;
            end
          endcase
          if (res_kind == KIND_STATUS && nc != cur_q) res_eff = EFF_MOVED;
        end else begin
          res_kind = KIND_CANCEL;
          nf       = '0;
          nc       = '0;
        end
      end
      ESC_DELX: begin
        ne     = ESC_IDLE;
        res_en = 1'b1;
        if (cur_q < fill_q) begin
          res_eff = EFF_REMOVED;
          nf      = fill_q - CW'(1);
          np      = cur_q;
          nl      = fill_q - CW'(1);
          op      = OP_SHIFT_L;
        end
      end
      ESC_IDLE: begin
        if (key_byte_i == KEY_ESC) begin
          ne = ESC_SEEN;
        end else if (key_byte_i == KEY_LF) begin
          nf = '0;
          nc = '0;
          if (fill_q == '0) begin
            res_en   = 1'b1;
            res_kind = KIND_EMPTY;
          end else begin
            np = '0;
            nl = fill_q - CW'(1);
            op = OP_EMIT;
          end
        end else if (key_byte_i == KEY_BS) begin
          res_en = 1'b1;
          if (cur_q != '0) begin
            res_eff = EFF_REMOVED;
            nc      = cur_q - CW'(1);
            nf      = fill_q - CW'(1);
            np      = cur_q - CW'(1);
            nl      = fill_q - CW'(1);
            op      = OP_SHIFT_L;
          end
        end else begin
          res_en = 1'b1;
          if (key_byte_i[BYTE_W-1] || key_byte_i[CHAR_W-1:0] < low_q ||
              key_byte_i[CHAR_W-1:0] > high_q) begin
            res_eff = EFF_NONE;
          end else if (fill_x >= cap_x) begin
            res_eff = EFF_FULL;
          end else begin
            res_eff = EFF_INSERTED;
            np      = fill_q;
            nl      = cur_q;
            nkey    = key_byte_i[CHAR_W-1:0];
            nc      = cur_q + CW'(1);
            nf      = fill_q + CW'(1);
            op      = OP_SHIFT_R;
          end
        end
      end
      default: ne = ESC_IDLE;
    endcase
  end

  // apply the decode, step the shifts and emission, load the result word
  always_comb begin
    fill_d      = fill_q;
    cur_d       = cur_q;
    ptr_d       = ptr_q;
    lim_d       = lim_q;
    esc_d       = esc_q;
    first_d     = first_q;
    key_d       = key_q;
    wr_pend_d   = 1'b0;
    wr_key_d    = wr_key_q;
    wr_addr_d   = wr_addr_q;
    em_pend_d   = 1'b0;
    em_last_d   = em_last_q;
    ren         = 1'b0;
    raddr       = '0;
    out_valid_d = 1'b0;
    kind_d      = kind_q;
    char_d      = char_q;
    curo_d      = curo_q;
    leno_d      = leno_q;
    eff_d       = eff_q;
    last_d      = last_q;

    if (cmd_i.accept) begin
      fill_d  = nf;
      cur_d   = nc;
      ptr_d   = np;
      lim_d   = nl;
      esc_d   = ne;
      first_d = nfirst;
      key_d   = nkey;
      if (res_en) begin
        out_valid_d = 1'b1;
        kind_d      = res_kind;
        char_d      = '0;
        curo_d      = POS_W'(nc);
        leno_d      = POS_W'(nf);
        eff_d       = res_eff;
        last_d      = 1'b1;
      end
    end

    if (cmd_i.shift_r) begin
      wr_pend_d = 1'b1;
      wr_addr_d = ptr_q[AW-1:0];
      if (ptr_q != lim_q) begin
        ren      = 1'b1;
        raddr    = AW'(ptr_q - CW'(1));
        wr_key_d = 1'b0;
        ptr_d    = ptr_q - CW'(1);
      end else begin
        wr_key_d = 1'b1;
      end
    end

    if (cmd_i.shift_l && ptr_q != lim_q) begin
      ren       = 1'b1;
      raddr     = AW'(ptr_q + CW'(1));
      wr_pend_d = 1'b1;
      wr_key_d  = 1'b0;
      wr_addr_d = ptr_q[AW-1:0];
      ptr_d     = ptr_q + CW'(1);
    end

    if (cmd_i.emit) begin
      ren       = 1'b1;
      raddr     = ptr_q[AW-1:0];
      em_pend_d = 1'b1;
      em_last_d = (ptr_q == lim_q);
      if (ptr_q != lim_q) ptr_d = ptr_q + CW'(1);
    end

    if (em_pend_q) begin
      out_valid_d = 1'b1;
      kind_d      = KIND_CHAR;
      char_d      = rd_q;
      curo_d      = '0;
      leno_d      = '0;
      eff_d       = EFF_NONE;
      last_d      = em_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      mem_q[wr_addr_q] <= wr_key_q ? key_q : rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ren) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      cur_q       <= '0;
      ptr_q       <= '0;
      lim_q       <= '0;
      esc_q       <= ESC_IDLE;
      first_q     <= '0;
      cap_q       <= CAP_RESET;
      low_q       <= LOW_RESET;
      high_q      <= HIGH_RESET;
      wr_pend_q   <= 1'b0;
      wr_key_q    <= 1'b0;
      em_pend_q   <= 1'b0;
      em_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      cur_q       <= cur_d;
      ptr_q       <= ptr_d;
      lim_q       <= lim_d;
      esc_q       <= esc_d;
      first_q     <= first_d;
      wr_pend_q   <= wr_pend_d;
      wr_key_q    <= wr_key_d;
      em_pend_q   <= em_pend_d;
      em_last_q   <= em_last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CAPACITY: cap_q  <= CAP_W'(cfg_data_i);
          REG_INS_LOW:  low_q  <= cfg_data_i;
          REG_INS_HIGH: high_q <= cfg_data_i;
          default:      cap_q  <= cap_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    wr_addr_q <= wr_addr_d;
    kind_q    <= kind_d;
    char_q    <= char_d;
    curo_q    <= curo_d;
    leno_q    <= leno_d;
    eff_q     <= eff_d;
    last_q    <= last_d;
  end

  assign stat_o.op     = op;
  assign stat_o.at_lim = (ptr_q == lim_q);
  assign stat_o.pend   = wr_pend_q | em_pend_q;

  assign result_valid_o = out_valid_q;
  assign result_kind_o  = kind_q;
  assign char_out_o     = char_q;
  assign cursor_pos_o   = curo_q;
  assign line_len_o     = leno_q;
  assign key_effect_o   = eff_q;
  assign last_item_o    = last_q;

endmodule

// ===== hw/rtl/terminal_line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// terminal_line_edit_buffer
// Line editor for a raw terminal byte stream.
//
// A byte is taken on key_byte_i at a clock edge with start high and busy low.
// Configuration (capacity, insert range) is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write it only while the block is
// idle, which the block itself does not enforce. Every result word appears
// for one cycle with result_valid_o high; the receiver takes it then and
// cannot stall the block. Cursor keys and refused inserts give their word in
// the cycle after the byte; the escape byte and the byte after it give none.
// Busy stays low for all of these, so a byte can follow every cycle. An
// insert keeps busy high while the store moves the characters from the cursor
// on right by one and writes the key at the cursor; a removal while it moves
// the later characters left by one. Enter puts out one character per cycle,
// each via the store read register and the result register, from line start.
// Reset clears length, cursor and escape state and loads the default
// configuration; the line store holds no reset value and needs no clearing.
// ----------------------------------------------------------------------------
module terminal_line_edit_buffer
  import tleb_pkg::*;
#(
  parameter int MAX_LEN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [BYTE_W-1:0] key_byte_i,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CHAR_W-1:0] cfg_data_i,
  output logic              result_valid_o,
  output logic [1:0]        result_kind_o,
  output logic [CHAR_W-1:0] char_out_o,
  output logic [POS_W-1:0]  cursor_pos_o,
  output logic [POS_W-1:0]  line_len_o,
  output logic [2:0]        key_effect_o,
  output logic              last_item_o
);

  cmd_t  cmd;
  stat_t stat;

  tleb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tleb_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .key_byte_i     (key_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .char_out_o     (char_out_o),
    .cursor_pos_o   (cursor_pos_o),
    .line_len_o     (line_len_o),
    .key_effect_o   (key_effect_o),
    .last_item_o    (last_item_o)
  );

endmodule

// ===== hw/rtl/tleb_checker.sv =====
// ----------------------------------------------------------------------------
// tleb_checker
// Port-level checks on the result words of the line edit buffer.
// ----------------------------------------------------------------------------
module tleb_checker
  import tleb_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy,
  input logic              result_valid_o,
  input logic [1:0]        result_kind_o,
  input logic [CHAR_W-1:0] char_out_o,
  input logic [POS_W-1:0]  cursor_pos_o,
  input logic [POS_W-1:0]  line_len_o,
  input logic [2:0]        key_effect_o,
  input logic              last_item_o
);

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o != KIND_CHAR |-> last_item_o)
    else $error("single word without last flag");

  a_line_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o != KIND_STATUS |->
      cursor_pos_o == '0 && line_len_o == '0 && key_effect_o == EFF_NONE)
    else $error("line word carries key status");

  a_char_only_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o != KIND_CHAR |-> char_out_o == '0)
    else $error("character on non-line word");

  a_busy_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == KIND_CHAR && !last_item_o |-> busy)
    else $error("idle while line still going out");

endmodule

bind terminal_line_edit_buffer tleb_checker u_tleb_checker (.*);

// ===== verif/tb_terminal_line_edit_buffer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_terminal_line_edit_buffer
// Self-checking bench for the terminal line edit buffer. Raw key bytes are
// driven through the start/busy handshake, a tracker class keeps its own copy
// of the line, cursor, escape state and registers, and every result word is
// compared against the oldest predicted word. The run walks through several
// register settings (capacity extremes, empty and single-value insert ranges)
// and several sender idle rates, with directed keys first and then mostly
// well-formed edit and escape sequences mixed with noise bytes.
// ----------------------------------------------------------------------------
module tb_terminal_line_edit_buffer;
  import tleb_pkg::*;

  localparam int LINE_MAX    = 32;
  localparam int NUM_PHASES  = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 33;
  localparam int DIRECTED_N  = 43;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  cur;
    logic [POS_W-1:0]  len;
    effect_e           eff;
    logic              last;
  } line_word_t;

  class edit_line_tracker;
    logic [CHAR_W-1:0] store [LINE_MAX];
    int unsigned       fill;
    int unsigned       cursor;
    int unsigned       cap;
    logic [CHAR_W-1:0] ins_lo;
    logic [CHAR_W-1:0] ins_hi;
    esc_e              esc_state;
    logic [BYTE_W-1:0] esc_first;
    line_word_t        expected_words [$];
    int                errors;

    function new();
      fill      = 0;
      cursor    = 0;
      cap       = CAP_RESET;
      ins_lo    = LOW_RESET;
      ins_hi    = HIGH_RESET;
      esc_state = ESC_IDLE;
      esc_first = '0;
      errors    = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void push(kind_e k, logic [CHAR_W-1:0] c, int unsigned cu, int unsigned ln,
                       effect_e e, logic lst);
      line_word_t w;
      w.kind = k;
      w.ch   = c;
      w.cur  = POS_W'(cu);
      w.len  = POS_W'(ln);
      w.eff  = e;
      w.last = lst;
      expected_words.push_back(w);
    endfunction

    function void status(effect_e e);
      push(KIND_STATUS, '0, cursor, fill, e, 1'b1);
    endfunction

    function void move_to(int unsigned target);
      effect_e e;
      e = (target != cursor) ? EFF_MOVED : EFF_NONE;
      cursor = target;
      status(e);
    endfunction

    function void remove_at(int unsigned pos);
      if (pos >= fill) return;
      for (int unsigned i = pos; i + 1 < fill; i++) store[i] = store[i + 1];
      fill--;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CHAR_W-1:0] data);
      case (idx)
        REG_CAPACITY: cap = data[CAP_W-1:0];
        REG_INS_LOW:  ins_lo = data;
        REG_INS_HIGH: ins_hi = data;
        default: ;
      endcase
    endfunction

    function void note_key(logic [BYTE_W-1:0] b);
      int unsigned lim;
      int unsigned n;
      case (esc_state)
        ESC_SEEN: begin
          esc_first = b;
          esc_state = ESC_FIRST;
          return;
        end
        ESC_FIRST: begin
          esc_state = ESC_IDLE;
          if (esc_first == KEY_CSI) begin
            if (b == KEY_LEFT) begin
              move_to(cursor > 0 ? cursor - 1 : 0);
              return;
            end
            if (b == KEY_RIGHT) begin
              move_to(cursor < fill ? cursor + 1 : cursor);
              return;
            end
            if (b == KEY_BOL) begin
              move_to(0);
              return;
            end
            if (b == KEY_END) begin
              move_to(fill);
              return;
            end
            if (b == KEY_DEL) begin
              esc_state = ESC_DELX;
              return;
            end
          end
          fill   = 0;
          cursor = 0;
          push(KIND_CANCEL, '0, 0, 0, EFF_NONE, 1'b1);
          return;
        end
        ESC_DELX: begin
          esc_state = ESC_IDLE;
          if (cursor >= fill) begin
            status(EFF_NONE);
          end else begin
            remove_at(cursor);
            status(EFF_REMOVED);
          end
          return;
        end
        default: ;
      endcase

      if (b == KEY_ESC) begin
        esc_state = ESC_SEEN;
      end else if (b == KEY_LF) begin
        n = (fill > LINE_MAX) ? LINE_MAX : fill;
        if (n == 0) begin
          push(KIND_EMPTY, '0, 0, 0, EFF_NONE, 1'b1);
        end else begin
          for (int unsigned i = 0; i < n; i++)
            push(KIND_CHAR, store[i], 0, 0, EFF_NONE, (i + 1 == n));
        end
        fill   = 0;
        cursor = 0;
      end else if (b == KEY_BS) begin
        if (cursor == 0) begin
          status(EFF_NONE);
        end else begin
          cursor--;
          remove_at(cursor);
          status(EFF_REMOVED);
        end
      end else begin
        lim = (cap > LINE_MAX) ? LINE_MAX : cap;
        if (b > 8'd127 || b < ins_lo || b > ins_hi) begin
          status(EFF_NONE);
        end else if (fill >= lim) begin
          status(EFF_FULL);
        end else begin
          for (int unsigned i = fill; i > cursor; i--) store[i] = store[i - 1];
          store[cursor] = b[CHAR_W-1:0];
          cursor++;
          fill++;
          status(EFF_INSERTED);
        end
      end
    endfunction

    function string fmt(line_word_t w);
      return $sformatf("kind=%0d char=%0d cursor=%0d len=%0d effect=%0d last=%0d",
                       w.kind, w.ch, w.cur, w.len, w.eff, w.last);
    endfunction

    function void check_word(line_word_t got);
      line_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("word with nothing expected: got %s", fmt(got));
        return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %s got %s", fmt(want), fmt(got));
      end
    endfunction
  endclass

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start      = 1'b0;
  logic              busy;
  logic [BYTE_W-1:0] key_byte_i = '0;
  logic              cfg_we_i   = 1'b0;
  logic [IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CHAR_W-1:0] cfg_data_i = '0;
  logic              result_valid_o;
  logic [1:0]        result_kind_o;
  logic [CHAR_W-1:0] char_out_o;
  logic [POS_W-1:0]  cursor_pos_o;
  logic [POS_W-1:0]  line_len_o;
  logic [2:0]        key_effect_o;
  logic              last_item_o;

  edit_line_tracker  sb;
  int                idle_pct     = 0;
  int                items_sent   = 0;
  int                quiet_cycles = 0;
  line_word_t        got_word;

  int phase_idle [NUM_PHASES] = '{0, 75, 34, 0, 75, 34, 75, 0};
  int phase_cap  [NUM_PHASES] = '{25, 1, 32, 64, 127, 4, 32, 3};
  int phase_lo   [NUM_PHASES] = '{97, 0, 32, 97, 0, 100, 48, 0};
  int phase_hi   [NUM_PHASES] = '{122, 127, 126, 122, 127, 90, 57, 0};

  logic [BYTE_W-1:0] directed_keys [] = '{
    KEY_BS,
    KEY_ESC, KEY_CSI, KEY_LEFT,
    KEY_ESC, KEY_CSI, KEY_DEL, 8'hFF,
    8'h00, 8'hFF, 8'h61, 8'h7A, 8'h60, 8'h7B,
    KEY_ESC, KEY_CSI, KEY_LEFT,
    8'h6D,
    KEY_ESC, KEY_CSI, KEY_RIGHT,
    KEY_ESC, KEY_CSI, KEY_RIGHT,
    KEY_ESC, KEY_CSI, KEY_BOL,
    KEY_ESC, KEY_CSI, KEY_DEL, KEY_ESC,
    KEY_ESC, KEY_CSI, KEY_END,
    KEY_BS, KEY_LF, KEY_LF,
    KEY_ESC, KEY_ESC, KEY_LF,
    8'h62, 8'h63, 8'h64
  };

  terminal_line_edit_buffer #(
    .MAX_LEN(LINE_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .key_byte_i     (key_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .char_out_o     (char_out_o),
    .cursor_pos_o   (cursor_pos_o),
    .line_len_o     (line_len_o),
    .key_effect_o   (key_effect_o),
    .last_item_o    (last_item_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_key(key_byte_i);
      if (result_valid_o) begin
        got_word.kind = kind_e'(result_kind_o);
        got_word.ch   = char_out_o;
        got_word.cur  = cursor_pos_o;
        got_word.len  = line_len_o;
        got_word.eff  = effect_e'(key_effect_o);
        got_word.last = last_item_o;
        sb.check_word(got_word);
      end
      if ((start && !busy) || result_valid_o || cfg_we_i) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL terminal_line_edit_buffer");
    $finish;
  end

  task automatic send_key(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    key_byte_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_random_key();
    int                pick;
    logic [BYTE_W-1:0] b;
    pick = $urandom_range(99);
    if (sb.ins_lo <= sb.ins_hi) b = BYTE_W'($urandom_range(sb.ins_hi, sb.ins_lo));
    else b = BYTE_W'($urandom_range(127, 0));
    if (pick < 45) begin
      send_key(b);
    end else if (pick < 56) begin
      send_key(KEY_ESC);
      send_key(KEY_CSI);
      case ($urandom_range(3))
        0: send_key(KEY_LEFT);
        1: send_key(KEY_RIGHT);
        2: send_key(KEY_BOL);
        default: send_key(KEY_END);
      endcase
    end else if (pick < 63) begin
      send_key(KEY_ESC);
      send_key(KEY_CSI);
      send_key(KEY_DEL);
      send_key(BYTE_W'($urandom_range(255)));
    end else if (pick < 71) begin
      send_key(KEY_BS);
    end else if (pick < 76) begin
      send_key(KEY_LF);
    end else if (pick < 81) begin
      send_key(KEY_ESC);
      send_key(BYTE_W'($urandom_range(255)));
      send_key(BYTE_W'($urandom_range(255)));
    end else if (pick < 85) begin
      send_key(KEY_ESC);
      send_key(KEY_CSI);
      send_key(BYTE_W'($urandom_range(255)));
    end else begin
      send_key(BYTE_W'($urandom_range(255)));
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_words.size() != 0 || busy) @(posedge clk_i);
    repeat (LINE_MAX + 8) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [CHAR_W-1:0] cap, lo, hi);
    logic [IDX_W-1:0]  idx [4];
    logic [CHAR_W-1:0] val [4];
    idx = '{REG_UNUSED, REG_CAPACITY, REG_INS_LOW, REG_INS_HIGH};
    val = '{CHAR_W'($urandom), cap, lo, hi};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct = phase_idle[p];
      if (p == 0) begin
        foreach (directed_keys[i]) send_key(directed_keys[i]);
      end else begin
        settle();
        load_config(CHAR_W'(phase_cap[p]), CHAR_W'(phase_lo[p]), CHAR_W'(phase_hi[p]));
      end
      while (items_sent < DIRECTED_N + (p + 1) * PHASE_ITEMS) send_random_key();
    end
    settle();
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("PASS terminal_line_edit_buffer");
    end else begin
      $display("FAIL terminal_line_edit_buffer");
    end
    $finish;
  end

endmodule
